// ===== rtl/dhlt_pkg.sv =====
// shared constants, types and rounding helpers of the link transform block
`default_nettype none
package dhlt_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int PIPE_DEPTH = CORDIC_LAT + 2;

	localparam int ZW = 34;
	localparam int ANGLE_W = 16;
	localparam int ROT_W = 16;
	localparam int LEN_W = 24;
	localparam int RP_W = 32;
	localparam int TP_W = 41;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW-1:0] GAIN_INV = 34'sd652032874;
	localparam logic signed [ANGLE_W-1:0] ANG_MAX = 16'sd25736;
	localparam logic signed [ROT_W-1:0] ROT_ONE = 16'sd16384;

	localparam logic CONV_MODIFIED = 1'b0;
	localparam logic CONV_CLASSIC = 1'b1;

	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [LEN_W-1:0] len_t;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524287;
			12: r = 34'sd262143;
			13: r = 34'sd131071;
			14: r = 34'sd65535;
			15: r = 34'sd32767;
			16: r = 34'sd16383;
			17: r = 34'sd8191;
			18: r = 34'sd4095;
			19: r = 34'sd2047;
			20: r = 34'sd1023;
			21: r = 34'sd511;
			22: r = 34'sd255;
			23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic rot_t clamp_angle(input logic signed [ANGLE_W-1:0] a);
		rot_t r;
		if (a > ANG_MAX) begin
			r = ANG_MAX;
		end else if (a < -ANG_MAX) begin
			r = -ANG_MAX;
		end else begin
			r = a;
		end
		return r;
	endfunction

	function automatic rot_t rot_round(input logic signed [RP_W-1:0] p);
		logic signed [RP_W-1:0] v;
		rot_t r;
		v = (p + RP_W'(8192)) >>> 14;
		if (v > RP_W'(16384)) begin
			r = ROT_ONE;
		end else if (v < -RP_W'(16384)) begin
			r = -ROT_ONE;
		end else begin
			r = v[ROT_W-1:0];
		end
		return r;
	endfunction

	function automatic len_t tr_round(input logic signed [TP_W-1:0] p);
		logic signed [TP_W-1:0] v;
		len_t r;
		v = (p + TP_W'(8192)) >>> 14;
		if (v > TP_W'(8388607)) begin
			r = 24'sh7fffff;
		end else if (v < -TP_W'(8388608)) begin
			r = 24'sh800000;
		end else begin
			r = v[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dhlt_cordic.sv =====
// pipelined rotation cordic giving cosine and sine of a clamped angle
`default_nettype none
module dhlt_cordic (
	input  wire logic clk,
	input  wire logic en,
	input  wire dhlt_pkg::rot_t angle,
	output dhlt_pkg::rot_t cos_q,
	output dhlt_pkg::rot_t sin_q
);
	localparam int N = dhlt_pkg::CORDIC_STEPS;
	localparam int ZW = dhlt_pkg::ZW;

	logic signed [ZW-1:0] x_s [0:N];
	logic signed [ZW-1:0] y_s [0:N];
	logic signed [ZW-1:0] z_s [0:N];
	logic flip_s [0:N];

	logic signed [ZW-1:0] z_in;
	logic signed [ZW-1:0] z_fold;
	logic flip_in;

	always_comb begin
		z_in = ZW'(angle) <<< 17;
		z_fold = z_in;
		flip_in = 1'b0;
		if (z_in > dhlt_pkg::HALF_PI_Q30) begin
			z_fold = z_in - dhlt_pkg::PI_Q30;
			flip_in = 1'b1;
		end else if (z_in < -dhlt_pkg::HALF_PI_Q30) begin
			z_fold = z_in + dhlt_pkg::PI_Q30;
			flip_in = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= dhlt_pkg::GAIN_INV;
			y_s[0] <= '0;
			z_s[0] <= z_fold;
			flip_s[0] <= flip_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - dhlt_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + dhlt_pkg::atan_q30(i);
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	function automatic dhlt_pkg::rot_t trig_round(input logic signed [ZW-1:0] v,
			input logic flip);
		logic signed [ZW-1:0] t;
		dhlt_pkg::rot_t r;
		t = (v + ZW'(32768)) >>> 16;
		if (t > ZW'(16384)) begin
			r = dhlt_pkg::ROT_ONE;
		end else if (t < -ZW'(16384)) begin
			r = -dhlt_pkg::ROT_ONE;
		end else begin
			r = t[dhlt_pkg::ROT_W-1:0];
		end
		return flip ? -r : r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= trig_round(x_s[N], flip_s[N]);
			sin_q <= trig_round(y_s[N], flip_s[N]);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dh_link_transform.sv =====
// top level: denavit-hartenberg link transform with apb convention register
// throughput: one transaction per cycle, set by the fully pipelined cordic and multipliers
// a stall at the output holds every stage in place
// reset clears valid bits and the convention register (modified convention)
`default_nettype none
module dh_link_transform (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic signed [15:0] joint_angle,
	input  wire logic signed [15:0] link_twist,
	input  wire logic signed [23:0] link_offset,
	input  wire logic signed [23:0] link_length,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [23:0] m03,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [23:0] m13,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic signed [23:0] m23
);
	localparam int CL = dhlt_pkg::CORDIC_LAT;
	localparam int D = dhlt_pkg::PIPE_DEPTH;
	localparam int RP = dhlt_pkg::RP_W;
	localparam int TP = dhlt_pkg::TP_W;

	logic conv_q;
	logic [D-1:0] v_q;
	logic en;

	dhlt_pkg::len_t d_s [0:CL-1];
	dhlt_pkg::len_t a_s [0:CL-1];
	logic conv_s [0:CL-1];

	dhlt_pkg::rot_t c, s, ca, sa;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, conv_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= dhlt_pkg::CONV_MODIFIED;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			conv_q <= pwdata[0];
		end
	end

	assign en = !(v_q[D-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = v_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[D-2:0], in_valid};
		end
	end

	dhlt_cordic u_theta (
		.clk(clk), .en(en), .angle(dhlt_pkg::clamp_angle(joint_angle)),
		.cos_q(c), .sin_q(s)
	);

	dhlt_cordic u_alpha (
		.clk(clk), .en(en), .angle(dhlt_pkg::clamp_angle(link_twist)),
		.cos_q(ca), .sin_q(sa)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= link_offset;
			a_s[0] <= link_length;
			conv_s[0] <= conv_q;
			for (int i = 1; i < CL; i++) begin
				d_s[i] <= d_s[i-1];
				a_s[i] <= a_s[i-1];
				conv_s[i] <= conv_s[i-1];
			end
		end
	end

	// product stage
	logic signed [RP-1:0] p_sca_s, p_cca_s, p_ssa_s, p_csa_s;
	logic signed [TP-1:0] p_t0_s, p_t1_s;
	dhlt_pkg::rot_t c_s, s_s, ca_s, sa_s;
	dhlt_pkg::len_t d_m, a_m;
	logic conv_m;

	always_ff @(posedge clk) begin
		if (en) begin
			p_sca_s <= RP'(s) * RP'(ca);
			p_cca_s <= RP'(c) * RP'(ca);
			p_ssa_s <= RP'(s) * RP'(sa);
			p_csa_s <= RP'(c) * RP'(sa);
			if (conv_s[CL-1] == dhlt_pkg::CONV_MODIFIED) begin
				p_t0_s <= TP'(d_s[CL-1]) * TP'(sa);
				p_t1_s <= TP'(d_s[CL-1]) * TP'(ca);
			end else begin
				p_t0_s <= TP'(a_s[CL-1]) * TP'(c);
				p_t1_s <= TP'(a_s[CL-1]) * TP'(s);
			end
			c_s <= c;
			s_s <= s;
			ca_s <= ca;
			sa_s <= sa;
			d_m <= d_s[CL-1];
			a_m <= a_s[CL-1];
			conv_m <= conv_s[CL-1];
		end
	end

	// rounding and selection stage
	always_ff @(posedge clk) begin
		if (en) begin
			m00 <= c_s;
			if (conv_m == dhlt_pkg::CONV_MODIFIED) begin
				m01 <= -s_s;
				m02 <= '0;
				m03 <= a_m;
				m10 <= dhlt_pkg::rot_round(p_sca_s);
				m11 <= dhlt_pkg::rot_round(p_cca_s);
				m12 <= -sa_s;
				m13 <= dhlt_pkg::tr_round(-p_t0_s);
				m20 <= dhlt_pkg::rot_round(p_ssa_s);
				m21 <= dhlt_pkg::rot_round(p_csa_s);
				m22 <= ca_s;
				m23 <= dhlt_pkg::tr_round(p_t1_s);
			end else begin
				m01 <= dhlt_pkg::rot_round(-p_sca_s);
				m02 <= dhlt_pkg::rot_round(p_ssa_s);
				m03 <= dhlt_pkg::tr_round(p_t0_s);
				m10 <= s_s;
				m11 <= dhlt_pkg::rot_round(p_cca_s);
				m12 <= dhlt_pkg::rot_round(-p_csa_s);
				m13 <= dhlt_pkg::tr_round(p_t1_s);
				m20 <= '0;
				m21 <= sa_s;
				m22 <= ca_s;
				m23 <= d_m;
			end
		end
	end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the denavit-hartenberg link transform block
`default_nettype none
module testbench;

	typedef struct {
		logic signed [15:0] theta;
		logic signed [15:0] alpha;
		logic signed [23:0] d;
		logic signed [23:0] a;
	} link_t;

	typedef struct {
		logic signed [15:0] r[9];
		logic signed [23:0] t[3];
	} frame_t;

	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint PI_FULL = 64'sd3373259426;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] joint_angle = '0, link_twist = '0;
	logic signed [23:0] link_offset = '0, link_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [23:0] m03, m13, m23;

	dh_link_transform uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	link_t pending_links[$];
	frame_t expected_frames[$];
	bit conv_sel = dhlt_pkg::CONV_MODIFIED;
	int errors = 0;
	int tx_gap = 0;
	bit allow_send = 1'b0;
	logic in_taken = 1'b0;

	longint atan_lut[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void sin_cos(longint ang, output longint c, output longint s);
		longint z, x, y, t;
		bit flip;
		z = ang * 131072;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > HALF_PI) begin
			z -= PI_FULL;
			flip = 1;
		end else if (z < -HALF_PI) begin
			z += PI_FULL;
			flip = 1;
		end
		for (int i = 0; i < dhlt_pkg::CORDIC_STEPS && i < 24; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_lut[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_lut[i];
			end
			x = t;
		end
		x = sat((x + 32768) >>> 16, -16384, 16384);
		y = sat((y + 32768) >>> 16, -16384, 16384);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint rot_mul(longint p, longint q);
		return sat((p * q + 8192) >>> 14, -16384, 16384);
	endfunction

	function automatic longint len_mul(longint p, longint q);
		return sat((p * q + 8192) >>> 14, -8388608, 8388607);
	endfunction

	function automatic frame_t link_frame(link_t l, bit conv);
		frame_t f;
		longint th, al, c, s, ca, sa;
		longint m[12];
		th = sat(l.theta, -25736, 25736);
		al = sat(l.alpha, -25736, 25736);
		sin_cos(th, c, s);
		sin_cos(al, ca, sa);
		if (conv == dhlt_pkg::CONV_MODIFIED) begin
			m = '{c, -s, 0, l.a, rot_mul(s, ca), rot_mul(c, ca), -sa, len_mul(l.d, -sa),
				rot_mul(s, sa), rot_mul(c, sa), ca, len_mul(l.d, ca)};
		end else begin
			m = '{c, rot_mul(-s, ca), rot_mul(s, sa), len_mul(l.a, c), s, rot_mul(c, ca),
				rot_mul(-c, sa), len_mul(l.a, s), 0, sa, ca, l.d};
		end
		for (int k = 0; k < 12; k++) begin
			if (k % 4 == 3) f.t[k / 4] = m[k][23:0];
			else f.r[(k / 4) * 3 + k % 4] = m[k][15:0];
		end
		return f;
	endfunction

	// input handshake seen at the rising edge
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
	end

	// driver
	always @(negedge clk) begin
		if (in_taken) begin
			expected_frames = {expected_frames, link_frame(pending_links[0], conv_sel)};
			pending_links.delete(0);
			tx_gap = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0) tx_gap = 0;
		end
		if (!in_valid || in_taken) begin
			if (allow_send && pending_links.size() > 0 && tx_gap == 0) begin
				in_valid <= 1'b1;
				joint_angle <= pending_links[0].theta;
				link_twist <= pending_links[0].alpha;
				link_offset <= pending_links[0].d;
				link_length <= pending_links[0].a;
			end else begin
				in_valid <= 1'b0;
				if (tx_gap > 0) tx_gap--;
			end
		end
	end

	// monitor
	logic signed [15:0] got_r[9];
	logic signed [23:0] got_t[3];
	int rx_wait = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got_r = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			got_t = '{m03, m13, m23};
			if (expected_frames.size() == 0) begin
				$error("unexpected transaction");
				errors++;
			end else begin
				frame_t e;
				e = expected_frames.pop_front();
				for (int k = 0; k < 9; k++)
					if (got_r[k] !== e.r[k]) begin
						$error("m%0d%0d expected %0d got %0d", k / 3, k % 3, e.r[k], got_r[k]);
						errors++;
					end
				for (int k = 0; k < 3; k++)
					if (got_t[k] !== e.t[k]) begin
						$error("m%0d3 expected %0d got %0d", k, e.t[k], got_t[k]);
						errors++;
					end
			end
		end
	end

	always @(negedge clk) begin
		if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_wait = $urandom_range(0, 8);
			out_stall <= (rx_wait > 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic add_link(int th, int al, int d, int a);
		link_t l;
		l.theta = 16'(th);
		l.alpha = 16'(al);
		l.d = 24'(d);
		l.a = 24'(a);
		pending_links = {pending_links, l};
	endtask

	task automatic drain;
		allow_send = 1'b1;
		while (pending_links.size() > 0 || expected_frames.size() > 0) @(posedge clk);
		allow_send = 1'b0;
		repeat (dhlt_pkg::CORDIC_STEPS + 10) @(posedge clk);
	endtask

	task automatic write_convention(bit v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= {31'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		conv_sel = v;
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				add_link($urandom, $urandom, $urandom, $urandom);
			else
				add_link($urandom_range(0, 51472) - 25736, $urandom_range(0, 51472) - 25736,
					$urandom, $urandom);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		for (int p = 0; p < 2; p++) begin
			if (p == 1) write_convention(dhlt_pkg::CONV_CLASSIC);
			add_link(0, 0, 0, 0);
			add_link(25736, -25736, 8388607, -8388608);
			add_link(-25736, 25736, -8388608, 8388607);
			add_link(32767, -32768, 8388607, 8388607);
			add_link(-32768, 32767, -8388608, -8388608);
			add_link(12868, 12868, 8388607, 8388607);
			add_link(-12868, 6434, -8388608, 65536);
			add_link(12869, -12869, 65536, -65536);
			add_link(-1, 1, -1, 1);
			add_link(16'sh5555, 16'shaaaa, 24'h555555, 24'haaaaaa);
			drain();
		end
		for (int ph = 0; ph < 6; ph++) begin
			write_convention(ph[0]);
			add_random(150);
			drain();
		end
		write_convention(dhlt_pkg::CONV_MODIFIED);
		drain();
		if (errors == 0) $display("testbench: clean");
		else $display("testbench: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end
endmodule
`default_nettype wire
